/* sv/rsgf_pkg.sv */
// Shared constants, types and GF(64) arithmetic for the RS(63,42) codeword checker.
// Used by rsgf_cell and rs_gf64_codeword_check_top; depends on nothing else.
`default_nettype none

package rsgf_pkg;

  // Symbol width and number of remainder stages (degree of the generator).
  localparam int unsigned SymW          = 6;
  localparam int unsigned ParitySymbols = 21;

  // Field polynomial x^6 + x + 1.
  localparam logic [SymW:0] GfPoly = 7'h43;

  // Generator coefficients, index equals degree; the top entry is the monic 1.
  localparam logic [SymW-1:0] GenCoef [0:ParitySymbols] = '{
    6'd58, 6'd62, 6'd59, 6'd7,  6'd35, 6'd58, 6'd63, 6'd47, 6'd51, 6'd6,  6'd33,
    6'd43, 6'd44, 6'd27, 6'd7,  6'd53, 6'd39, 6'd62, 6'd52, 6'd41, 6'd44, 6'd1
  };

  typedef logic [SymW-1:0] sym_t;

  // Per-request control that every stage of the chain sees.
  typedef struct packed {
    logic shift;  // a request is taken this cycle
    logic clear;  // the request ends the codeword
  } cell_ctrl_t;

  // GF(64) multiply by shift and add, reduced by the field polynomial.
  function automatic sym_t gf_mul(input sym_t a, input sym_t b);
    logic [SymW:0] x;
    sym_t          acc;
    x   = {1'b0, a};
    acc = '0;
    for (int k = 0; k < SymW; k++) begin
      if (b[k]) begin
        acc = acc ^ x[SymW-1:0];
      end
      x = {x[SymW-1:0], 1'b0};
      if (x[SymW]) begin
        x = x ^ GfPoly;
      end
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

/* sv/rsgf_cell.sv */
// One stage of the generator-division LFSR: holds one remainder coefficient.
// Depends on rsgf_pkg for the symbol type, control struct and GF multiply.
`default_nettype none

module rsgf_cell (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire rsgf_pkg::cell_ctrl_t ctrl_i,
  input  wire rsgf_pkg::sym_t       coef_i,
  input  wire rsgf_pkg::sym_t       feedback_i,
  input  wire rsgf_pkg::sym_t       prev_i,
  output rsgf_pkg::sym_t            rem_o,
  output logic                      nonzero_o
);

  rsgf_pkg::sym_t rem_q;
  rsgf_pkg::sym_t rem_d;

  // Shift in the lower neighbor and fold back the leaving top coefficient.
  assign rem_d     = prev_i ^ rsgf_pkg::gf_mul(feedback_i, coef_i);
  assign nonzero_o = |rem_d;
  assign rem_o     = rem_q;

  // The remainder clears once the last symbol of a codeword is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (ctrl_i.shift) begin
      rem_q <= ctrl_i.clear ? '0 : rem_d;
    end
  end

endmodule

`default_nettype wire

/* sv/rs_gf64_codeword_check_top.sv */
// RS(63,42) GF(64) codeword checker: a 21-stage LFSR divides by the generator.
// One symbol request is taken per cycle while in_ready_o is high; the check
// result of a codeword appears in the output register in the cycle after its
// last symbol is taken. The rate is set by the LFSR update of the cell chain.
// Reset clears the remainder chain and the output register; no clearing pass.
// Depends on rsgf_pkg and rsgf_cell.
`default_nettype none

module rs_gf64_codeword_check_top (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire  [5:0] symbol_i,
  input  wire        last_symbol_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic       codeword_valid_o
);

  localparam int unsigned NCells = rsgf_pkg::ParitySymbols;

  rsgf_pkg::sym_t       rem     [NCells];
  logic [NCells-1:0]    nonzero;
  rsgf_pkg::cell_ctrl_t ctrl;
  logic                 in_acc;
  logic                 out_valid_q;
  logic                 result_q;

  // The output register frees up in the same cycle it is drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign ctrl.shift = in_acc;
  assign ctrl.clear = last_symbol_i;

  // Chain of remainder stages; stage zero takes the incoming symbol.
  for (genvar i = 0; i < NCells; i++) begin : g_cell
    rsgf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .coef_i     (rsgf_pkg::GenCoef[i]),
      .feedback_i (rem[NCells-1]),
      .prev_i     ((i == 0) ? symbol_i : rem[(i == 0) ? 0 : i-1]),
      .rem_o      (rem[i]),
      .nonzero_o  (nonzero[i])
    );
  end

  // Result register: loaded on the last symbol, held until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      result_q    <= 1'b0;
    end else if (in_acc && last_symbol_i) begin
      out_valid_q <= 1'b1;
      result_q    <= ~|nonzero;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign codeword_valid_o = result_q;

  // After a codeword ends, the first, middle and last remainder stages are zero.
  a_clear_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_symbol_i |=> (rem[0] == '0) && (rem[NCells-1] == '0)
      && (rem[NCells/2] == '0))
    else $error("remainder not cleared after last symbol");

  // A result only appears as the answer to a last symbol.
  a_result_source : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_acc && last_symbol_i))
    else $error("result without a last symbol");

  // Input is held back only while an untaken result blocks the register.
  a_ready_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

  // A last symbol always produces a pending result in the next cycle.
  a_last_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_symbol_i |=> out_valid_o && (codeword_valid_o == $past(~|nonzero)))
    else $error("result of last symbol lost");

endmodule

`default_nettype wire
